### design/u8sd_pkg.sv
package u8sd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 31;
  localparam int unsigned OwedW  = 3;
  localparam int unsigned ContW  = 6;

  // lead byte class boundaries
  localparam logic [ByteW-1:0] Lead2Lim = 8'b1110_0000;
  localparam logic [ByteW-1:0] Lead3Lim = 8'b1111_0000;
  localparam logic [ByteW-1:0] Lead4Lim = 8'b1111_1000;
  localparam logic [ByteW-1:0] Lead5Lim = 8'b1111_1100;
  localparam logic [ByteW-1:0] AsciiLim = 8'h80;

  // lead payload masks
  localparam logic [ByteW-1:0] Lead2Mask = 8'h1F;
  localparam logic [ByteW-1:0] Lead3Mask = 8'h0F;
  localparam logic [ByteW-1:0] Lead4Mask = 8'h07;
  localparam logic [ByteW-1:0] Lead5Mask = 8'h03;
  localparam logic [ByteW-1:0] Lead6Mask = 8'h01;

  localparam logic [CpW-1:0] SurrLo = 31'h0000_D800;
  localparam logic [CpW-1:0] SurrHi = 31'h0000_DFFF;

  localparam logic [OwedW-1:0] OwedMax = 3'd5;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SURROGATE = 2'd1,
    ST_TRUNCATED = 2'd2
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] byte_in;
    logic             end_of_string;
  } in_t;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    status_e        status;
    logic           string_done;
  } out_t;

  typedef struct packed {
    logic [OwedW-1:0] bytes_owed;
    logic [CpW-1:0]   partial_value;
  } dec_state_t;

endpackage

### design/u8sd_step.sv
module u8sd_step
  import u8sd_pkg::*;
(
  input  in_t        req_i,
  input  dec_state_t cur_i,
  output dec_state_t nxt_o,
  output logic       res_valid_o,
  output out_t       res_o
);

  logic [ByteW-1:0] b;
  logic [CpW-1:0]   value;
  logic             fin;

  always_comb begin
    b           = req_i.byte_in;
    nxt_o       = cur_i;
    value       = '0;
    fin         = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '{code_point: '0, status: ST_OK, string_done: req_i.end_of_string};

    if (cur_i.bytes_owed == '0) begin
      if (b < AsciiLim) begin
        fin   = 1'b1;
        value = CpW'(b);
      end else if (b < Lead2Lim) begin
        nxt_o.partial_value = CpW'(b & Lead2Mask);
        nxt_o.bytes_owed    = 3'd1;
      end else if (b < Lead3Lim) begin
        nxt_o.partial_value = CpW'(b & Lead3Mask);
        nxt_o.bytes_owed    = 3'd2;
      end else if (b < Lead4Lim) begin
        nxt_o.partial_value = CpW'(b & Lead4Mask);
        nxt_o.bytes_owed    = 3'd3;
      end else if (b < Lead5Lim) begin
        nxt_o.partial_value = CpW'(b & Lead5Mask);
        nxt_o.bytes_owed    = 3'd4;
      end else begin
        nxt_o.partial_value = CpW'(b & Lead6Mask);
        nxt_o.bytes_owed    = OwedMax;
      end
    end else begin
      // continuation tag bits are ignored
      value            = {cur_i.partial_value[CpW-ContW-1:0], b[ContW-1:0]};
      nxt_o.bytes_owed = cur_i.bytes_owed - 3'd1;
      if (nxt_o.bytes_owed == '0) begin
        fin                 = 1'b1;
        nxt_o.partial_value = '0;
      end else begin
        nxt_o.partial_value = value;
      end
    end

    if (fin) begin
      res_valid_o = 1'b1;
      if (value >= SurrLo && value <= SurrHi) begin
        res_o.status = ST_SURROGATE;
      end else begin
        res_o.code_point = value;
      end
    end else if (req_i.end_of_string) begin
      // string ended mid-sequence
      res_valid_o       = 1'b1;
      res_o.status      = ST_TRUNCATED;
      res_o.string_done = 1'b1;
      nxt_o             = '0;
    end
  end

endmodule

### design/u8sd_out_buf.sv
module u8sd_out_buf
  import u8sd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  out_t push_data_i,
  output logic full_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  out_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign full_o      = (cnt_q == 2'd2);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### design/utf8_stream_decoder.sv
// streaming utf-8 decoder: one byte is taken per clock whenever in_stall_o is low, so a
// byte stream flows at one byte per cycle; a finished code point (or a surrogate /
// truncation error) is written into the result buffer, which drives the output.
// lead bytes may open sequences of up to six bytes, continuation tag bits are not
// checked, and a string that ends inside a sequence yields a truncation error and a
// clean state. the output side has a two-entry buffer, so in_stall_o rises only when
// two results wait; the per-byte update is one shallow pass between the state and the
// result buffer, which sets the one-byte-per-clock rate
module utf8_stream_decoder
  import u8sd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  // decoder state: owed continuation bytes and partial code point
  dec_state_t state_q, state_d;
  dec_state_t step_nxt;
  logic       res_valid;
  out_t       res;
  logic       buf_full;
  logic       in_acc;

  // a request is taken whenever the result buffer has room
  assign in_stall_o = buf_full;
  assign in_acc     = in_valid_i && !buf_full;

  u8sd_step u_step (
    .req_i       (in_data_i),
    .cur_i       (state_q),
    .nxt_o       (step_nxt),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // state advances only on an accepted request
  always_comb begin
    state_d = state_q;
    if (in_acc) begin
      state_d = step_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  // result buffer decouples the output stall from the input side
  u8sd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_acc && res_valid),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // never more than five continuation bytes owed
  a_owed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.bytes_owed <= OwedMax)
    else $error("bytes_owed out of range");

  // an error result carries a zero code point
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |-> out_data_o.code_point == '0)
    else $error("error result with nonzero code point");

  // a truncation always closes its string
  a_trunc_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_TRUNCATED |-> out_data_o.string_done)
    else $error("truncation without string_done");

  // end of string leaves no pending sequence
  a_eos_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.end_of_string |=> state_q == '0)
    else $error("state not cleared at end of string");

  // stall only while results are waiting
  a_stall_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty result buffer");

endmodule
